### hdl/pie_pkg.sv
package pie_pkg;

    // Color space and presence bitmap geometry.
    localparam int COLOR_BITS = 16;
    localparam int WORD_BITS = 64;
    localparam int NUM_COLORS = 2 ** COLOR_BITS;
    localparam int NUM_WORDS = NUM_COLORS / WORD_BITS;
    localparam int WADDR_BITS = $clog2(NUM_WORDS);
    localparam int BSEL_BITS = $clog2(WORD_BITS);

    // Counters must hold the full color count itself.
    localparam int COUNT_BITS = COLOR_BITS + 1;

    // Index width ranges from zero to COLOR_BITS.
    localparam int NB_BITS = $clog2(COLOR_BITS + 1);

    // Packing: up to seven pending bits plus one full index.
    localparam int ACC_BITS = 8 + COLOR_BITS;
    localparam int TOT_BITS = $clog2(7 + COLOR_BITS + 1);
    localparam int NBYTE_BITS = TOT_BITS - 3;
    localparam int MAX_ENC_BYTES = (7 + COLOR_BITS) / 8;

    // Per-item result buffer.
    localparam int MAX_RES = 4;
    localparam int RPTR_BITS = $clog2(MAX_RES);
    localparam int RCNT_BITS = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        MODE_SCAN   = 2'd0,
        MODE_BUILD  = 2'd1,
        MODE_ENCODE = 2'd2,
        MODE_FLUSH  = 2'd3
    } pie_mode_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_PARTIAL = 2'd3
    } pie_kind_t;

    typedef struct packed {
        logic                  en;
        logic [WADDR_BITS-1:0] bm_addr;
        logic [COLOR_BITS-1:0] rm_addr;
    } pie_rd_t;

    typedef struct packed {
        logic                  bm_we;
        logic [WADDR_BITS-1:0] bm_addr;
        logic [WORD_BITS-1:0]  bm_data;
        logic                  rm_we;
        logic [COLOR_BITS-1:0] rm_addr;
        logic [COLOR_BITS-1:0] rm_data;
    } pie_wr_t;

    typedef struct packed {
        logic [7:0] data;
        pie_kind_t  kind;
        logic       err;
    } pie_res_t;

    // Number of bits needed to code an index below count; zero for count of 0 or 1.
    function automatic logic [NB_BITS-1:0] index_width(input logic [COUNT_BITS-1:0] count);
        logic [COUNT_BITS-1:0] m;
        logic [NB_BITS-1:0]    n;
        m = count - COUNT_BITS'(1);
        n = '0;
        if (count > COUNT_BITS'(1))
        begin
            for (int i = 0; i < COUNT_BITS; i++)
            begin
                if (m[i])
                begin
                    n = NB_BITS'(i + 1);
                end
            end
        end
        return n;
    endfunction

endpackage

### hdl/pie_store.sv
// Presence bitmap and reverse map memories. The bitmap is swept to zero
// after reset, one word per cycle; the reverse map is never cleared.
module pie_store
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pie_pkg::pie_rd_t               rd,
    input  pie_pkg::pie_wr_t               wr,
    output logic [pie_pkg::WORD_BITS-1:0]  bm_rdata,
    output logic [pie_pkg::COLOR_BITS-1:0] rm_rdata,
    output logic                           busy
);

    logic [pie_pkg::WORD_BITS-1:0]  bm_mem [pie_pkg::NUM_WORDS];
    logic [pie_pkg::COLOR_BITS-1:0] rm_mem [pie_pkg::NUM_COLORS];

    logic [pie_pkg::WADDR_BITS-1:0] clr_addr_reg;
    logic [pie_pkg::WADDR_BITS-1:0] clr_addr_next;
    logic                           clr_busy_reg;
    logic                           clr_busy_next;
    logic [pie_pkg::WORD_BITS-1:0]  bm_rdata_reg;
    logic [pie_pkg::COLOR_BITS-1:0] rm_rdata_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            bm_mem[clr_addr_reg] <= '0;
        end
        else if (wr.bm_we)
        begin
            bm_mem[wr.bm_addr] <= wr.bm_data;
        end
        if (rd.en)
        begin
            bm_rdata_reg <= bm_mem[rd.bm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.rm_we)
        begin
            rm_mem[wr.rm_addr] <= wr.rm_data;
        end
        if (rd.en)
        begin
            rm_rdata_reg <= rm_mem[rd.rm_addr];
        end
    end

    assign bm_rdata = bm_rdata_reg;
    assign rm_rdata = rm_rdata_reg;
    assign busy     = clr_busy_reg;

endmodule

### hdl/palette_index_encoder.sv
// Palette index encoder for 16-bit colors. Scan transfers (mode 0) mark each
// color in a 1024 x 64 presence bitmap and count the distinct colors until
// the first build transfer; build transfers (mode 1) walk the color values in
// ascending order, give each present color the next palette index and emit
// the color as two little-endian bytes, the first build transfer being
// preceded by the 2-byte palette size; encode transfers (mode 2) emit the
// packed palette index of a color, LSB first, in ceil(log2(count)) bits, one
// byte per completed byte, or a single error result when the color is not in
// the palette yet; flush transfers (mode 3) emit the pending partial byte.
// After reset the block holds off input while it clears the bitmap, one word
// per cycle. Items are handled one at a time: a transfer is taken in the
// cycle that also launches the memory read, and the next cycle uses the read
// data, writes back and produces the results. Each result is then moved into
// the output register in turn while the output side does not stall. The next
// transfer is taken while the last result of the previous item still waits
// in the output register.
module palette_index_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  byte_kind,
    output logic        error,
    output logic        last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam int CB = pie_pkg::COLOR_BITS;
    localparam int BS = pie_pkg::BSEL_BITS;
    localparam int CNTB = pie_pkg::COUNT_BITS;

    state_t state_reg;
    state_t state_next;

    // Item latched at acceptance.
    pie_pkg::pie_mode_t mode_reg;
    logic [CB-1:0]      color_reg;

    // Encoder state.
    logic [CNTB-1:0] count_reg;
    logic [CNTB-1:0] count_next;
    logic [CNTB-1:0] cursor_reg;
    logic [CNTB-1:0] cursor_next;
    logic [CNTB-1:0] index_reg;
    logic [CNTB-1:0] index_next;
    logic [7:0]      pack_reg;
    logic [7:0]      pack_next;
    logic [2:0]      pos_reg;
    logic [2:0]      pos_next;
    logic            hdr_sent_reg;
    logic            hdr_sent_next;

    // Results of the current item.
    pie_pkg::pie_res_t               res_reg [pie_pkg::MAX_RES];
    pie_pkg::pie_res_t               res_next [pie_pkg::MAX_RES];
    logic [pie_pkg::RCNT_BITS-1:0]   res_cnt_reg;
    logic [pie_pkg::RCNT_BITS-1:0]   res_cnt_next;
    logic [pie_pkg::RPTR_BITS-1:0]   res_ptr_reg;
    logic [pie_pkg::RPTR_BITS-1:0]   res_ptr_next;

    // Output register.
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [1:0] out_kind_reg;
    logic       out_error_reg;
    logic       out_last_reg;

    // Memory interface.
    pie_pkg::pie_rd_t         rd;
    pie_pkg::pie_wr_t         wr;
    logic [pie_pkg::WORD_BITS-1:0] bm_rdata;
    logic [CB-1:0]            rm_rdata;
    logic                     store_busy;

    logic                     accept;
    logic                     out_load;
    logic                     res_is_last;
    logic [CB-1:0]            in_color;
    pie_pkg::pie_mode_t       in_mode;

    // Execute-cycle intermediates.
    logic [BS-1:0]                  bit_sel;
    logic                           hit;
    logic                           miss;
    logic [15:0]                    count16;
    logic [15:0]                    cursor16;
    logic [pie_pkg::NB_BITS-1:0]    nb;
    logic [CB:0]                    idx_mask;
    logic [CB-1:0]                  idx;
    logic [pie_pkg::ACC_BITS-1:0]   acc;
    logic [pie_pkg::ACC_BITS-1:0]   acc_rest;
    logic [pie_pkg::TOT_BITS-1:0]   total;
    logic [pie_pkg::NBYTE_BITS-1:0] nbytes;
    logic [pie_pkg::RPTR_BITS-1:0]  base;

    pie_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .bm_rdata (bm_rdata),
        .rm_rdata (rm_rdata),
        .busy     (store_busy)
    );

    assign in_stall = (state_reg != ST_IDLE) || store_busy;
    assign accept   = in_valid && !in_stall;
    assign in_color = color[CB-1:0];
    assign in_mode  = pie_pkg::pie_mode_t'(mode);

    // The bitmap word is read at acceptance; build steps look at the cursor.
    always_comb
    begin
        rd.en      = accept;
        rd.rm_addr = in_color;
        if (in_mode == pie_pkg::MODE_BUILD)
        begin
            rd.bm_addr = cursor_reg[CB-1:BS];
        end
        else
        begin
            rd.bm_addr = in_color[CB-1:BS];
        end
    end

    assign count16  = 16'(count_reg);
    assign cursor16 = 16'(cursor_reg);
    assign nb       = pie_pkg::index_width(count_reg);
    assign idx_mask = ({{CB{1'b0}}, 1'b1} << nb) - 1'b1;
    assign idx      = rm_rdata & idx_mask[CB-1:0];
    assign acc      = pie_pkg::ACC_BITS'(pack_reg) | (pie_pkg::ACC_BITS'(idx) << pos_reg);
    assign total    = pie_pkg::TOT_BITS'(pos_reg) + pie_pkg::TOT_BITS'(nb);
    assign nbytes   = total[pie_pkg::TOT_BITS-1:3];
    assign acc_rest = acc >> {nbytes, 3'b000};

    always_comb
    begin
        if (mode_reg == pie_pkg::MODE_BUILD)
        begin
            bit_sel = cursor_reg[BS-1:0];
        end
        else
        begin
            bit_sel = color_reg[BS-1:0];
        end
        hit  = bm_rdata[bit_sel];
        miss = !hdr_sent_reg || ({1'b0, color_reg} >= cursor_reg) || !hit;
        base = hdr_sent_reg ? pie_pkg::RPTR_BITS'(0) : pie_pkg::RPTR_BITS'(2);
    end

    // Execute step: uses the read data, writes back and fills the result buffer.
    always_comb
    begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        index_next    = index_reg;
        pack_next     = pack_reg;
        pos_next      = pos_reg;
        hdr_sent_next = hdr_sent_reg;
        res_next      = res_reg;
        res_cnt_next  = res_cnt_reg;
        wr            = '0;
        wr.bm_addr    = color_reg[CB-1:BS];
        wr.bm_data    = bm_rdata | (pie_pkg::WORD_BITS'(1) << bit_sel);
        wr.rm_addr    = cursor_reg[CB-1:0];
        wr.rm_data    = index_reg[CB-1:0];

        if (state_reg == ST_EXEC)
        begin
            res_cnt_next = '0;
            case (mode_reg)
                pie_pkg::MODE_SCAN:
                begin
                    if (!hdr_sent_reg && !hit)
                    begin
                        wr.bm_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                pie_pkg::MODE_BUILD:
                begin
                    if (!hdr_sent_reg)
                    begin
                        res_next[0]   = '{data: count16[7:0], kind: pie_pkg::KIND_HEADER,
                                          err: 1'b0};
                        res_next[1]   = '{data: count16[15:8], kind: pie_pkg::KIND_HEADER,
                                          err: 1'b0};
                        res_cnt_next  = pie_pkg::RCNT_BITS'(2);
                        hdr_sent_next = 1'b1;
                    end
                    if (!cursor_reg[CB])
                    begin
                        if (hit)
                        begin
                            wr.rm_we   = 1'b1;
                            index_next = index_reg + 1'b1;
                            res_next[base] = '{data: cursor16[7:0],
                                               kind: pie_pkg::KIND_ENTRY, err: 1'b0};
                            res_next[base + 1'b1] = '{data: cursor16[15:8],
                                                      kind: pie_pkg::KIND_ENTRY, err: 1'b0};
                            res_cnt_next = pie_pkg::RCNT_BITS'(base) + pie_pkg::RCNT_BITS'(2);
                        end
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
                pie_pkg::MODE_ENCODE:
                begin
                    if (miss)
                    begin
                        res_next[0]  = '{data: 8'h00, kind: pie_pkg::KIND_DATA, err: 1'b1};
                        res_cnt_next = pie_pkg::RCNT_BITS'(1);
                    end
                    else
                    begin
                        for (int k = 0; k < pie_pkg::MAX_ENC_BYTES; k++)
                        begin
                            res_next[k] = '{data: acc[8*k +: 8], kind: pie_pkg::KIND_DATA,
                                            err: 1'b0};
                        end
                        res_cnt_next = pie_pkg::RCNT_BITS'(nbytes);
                        pack_next    = acc_rest[7:0];
                        pos_next     = total[2:0];
                    end
                end
                pie_pkg::MODE_FLUSH:
                begin
                    if (pos_reg != 3'd0)
                    begin
                        res_next[0]  = '{data: pack_reg, kind: pie_pkg::KIND_PARTIAL,
                                         err: 1'b0};
                        res_cnt_next = pie_pkg::RCNT_BITS'(1);
                        pack_next    = '0;
                        pos_next     = '0;
                    end
                end
                default:
                begin
                    res_cnt_next = '0;
                end
            endcase
        end
    end

    // Results move one per cycle into the output register while the output side does not stall.
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign res_is_last = (pie_pkg::RCNT_BITS'(res_ptr_reg) + 1'b1) == res_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_ptr_next   = res_ptr_reg;
        out_valid_next = out_load || (out_valid_reg && out_stall);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_ptr_next = '0;
                if (res_cnt_next == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (res_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        res_ptr_next = res_ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            index_reg     <= '0;
            pack_reg      <= '0;
            pos_reg       <= '0;
            hdr_sent_reg  <= 1'b0;
            res_cnt_reg   <= '0;
            res_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            index_reg     <= index_next;
            pack_reg      <= pack_next;
            pos_reg       <= pos_next;
            hdr_sent_reg  <= hdr_sent_next;
            res_cnt_reg   <= res_cnt_next;
            res_ptr_reg   <= res_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_mode;
            color_reg <= in_color;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            out_byte_reg  <= res_reg[res_ptr_reg].data;
            out_kind_reg  <= res_reg[res_ptr_reg].kind;
            out_error_reg <= res_reg[res_ptr_reg].err;
            out_last_reg  <= res_is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign byte_kind = out_kind_reg;
    assign error     = out_error_reg;
    assign last      = out_last_reg;

endmodule

### bench/testbench.sv
module testbench;

    // About this many input transfers are sent in one run.
    localparam int ITEMS = 420;

    // Number of color values the build phase walks. The test image keeps
    // most of its colors below this value so that they reach the palette.
    localparam int BUILD_SPAN = 160;

    // The receiver holds off once for this many cycles so that the block
    // backs up and stalls its input side.
    localparam int HOLD_CYCLES = 300;

    // Cycles to linger after the last expected byte has come out, so that a
    // stray byte from an item with no expected output is still caught.
    localparam int TAIL_CYCLES = 40;

    // One input transfer as the stimulus generator plans it: the operation,
    // the pixel color and how many idle cycles the sender inserts before it.
    typedef struct {
        pie_pkg::pie_mode_t op;
        logic [15:0]        color;
        int                 gap;
    } pixel_op_t;

    // One byte of the encoded stream with its side-band flags.
    typedef struct packed {
        logic [7:0]         byte_val;
        pie_pkg::pie_kind_t kind;
        logic               err;
        logic               last;
    } stream_byte_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = pie_pkg::MODE_SCAN;
    logic [15:0] color = 16'h0000;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic        error;
    logic        last;

    // The output stall is the OR of the per-byte random wait and the single
    // long hold-off; each is driven by a process of its own.
    logic rx_stall = 1'b0;
    logic hold_stall = 1'b0;
    assign out_stall = rx_stall | hold_stall;

    palette_index_encoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .color     (color),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .byte_kind (byte_kind),
        .error     (error),
        .last      (last)
    );

    // Pending input transfers and the bytes the encoder is expected to emit.
    pixel_op_t    pending[$];
    stream_byte_t expected_stream[$];

    // Shadow copy of the encoder state, kept up to date transfer by transfer.
    bit          seen_color [0:65535];
    logic [15:0] index_of [0:65535];
    logic [16:0] color_count = '0;
    logic [16:0] scan_pos = '0;
    logic [16:0] palette_fill = '0;
    logic [7:0]  acc_byte = '0;
    logic [2:0]  acc_pos = '0;
    bit          header_done = 1'b0;

    // Handshake bookkeeping.
    pixel_op_t    cur_op;
    pixel_op_t    next_op;
    stream_byte_t want;
    bit           tx_loaded = 1'b0;
    bit           in_took = 1'b0;
    bit           rx_took = 1'b0;
    int           tx_wait = 0;
    int           tx_calm = 0;
    int           rx_wait = 0;
    int           rx_calm = 0;
    int           accepted_count = 0;
    int           hold_at = 32'h7fffffff;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           fail_count = 0;
    longint       cycle_count = 0;
    longint       cycle_limit = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Draws an idle count from 0 to 6, but now and then starts a calm
    // stretch of 11 to 41 transfers with no idling at all.
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Width of a palette index: the smallest n with 2**n >= count, so a
    // palette of zero or one color needs no bits at all.
    function automatic int code_bits(input logic [16:0] count);
        int n;
        n = 0;
        while (n < 17 && (32'd1 << n) < count)
        begin
            n++;
        end
        return n;
    endfunction

    function automatic stream_byte_t make_byte(input logic [7:0] b,
                                               input pie_pkg::pie_kind_t k,
                                               input logic e);
        stream_byte_t r;
        r.byte_val = b;
        r.kind = k;
        r.err = e;
        r.last = 1'b0;
        return r;
    endfunction

    // Advances the shadow encoder state by one accepted transfer and queues
    // the bytes it produces; the final byte of the transfer carries last.
    task automatic predict_stream(input pie_pkg::pie_mode_t op, input logic [15:0] c);
        stream_byte_t staged [0:3];
        stream_byte_t r;
        logic [16:0]  idx;
        int           nb;
        int           n;
        n = 0;
        case (op)
            pie_pkg::MODE_SCAN:
            begin
                // Once the header is out the palette is frozen.
                if (!header_done && !seen_color[c])
                begin
                    seen_color[c] = 1'b1;
                    color_count = color_count + 17'd1;
                end
            end
            pie_pkg::MODE_BUILD:
            begin
                if (!header_done)
                begin
                    staged[n] = make_byte(color_count[7:0], pie_pkg::KIND_HEADER, 1'b0);
                    n++;
                    staged[n] = make_byte(color_count[15:8], pie_pkg::KIND_HEADER, 1'b0);
                    n++;
                    header_done = 1'b1;
                end
                // Past the top color value, build steps do nothing.
                if (scan_pos < 17'h10000)
                begin
                    if (seen_color[scan_pos[15:0]])
                    begin
                        index_of[scan_pos[15:0]] = palette_fill[15:0];
                        palette_fill = palette_fill + 17'd1;
                        staged[n] = make_byte(scan_pos[7:0], pie_pkg::KIND_ENTRY, 1'b0);
                        n++;
                        staged[n] = make_byte(scan_pos[15:8], pie_pkg::KIND_ENTRY, 1'b0);
                        n++;
                    end
                    scan_pos = scan_pos + 17'd1;
                end
            end
            pie_pkg::MODE_ENCODE:
            begin
                // A color the build has not reached, or never saw, is an error
                // and leaves the bit packer untouched.
                if (!header_done || {1'b0, c} >= scan_pos || !seen_color[c])
                begin
                    staged[n] = make_byte(8'h00, pie_pkg::KIND_DATA, 1'b1);
                    n++;
                end
                else
                begin
                    idx = {1'b0, index_of[c]};
                    nb = code_bits(color_count);
                    for (int i = 0; i < nb; i++)
                    begin
                        if (idx[i])
                        begin
                            acc_byte[acc_pos] = 1'b1;
                        end
                        if (acc_pos == 3'd7)
                        begin
                            staged[n] = make_byte(acc_byte, pie_pkg::KIND_DATA, 1'b0);
                            n++;
                            acc_byte = '0;
                            acc_pos = '0;
                        end
                        else
                        begin
                            acc_pos = acc_pos + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                if (acc_pos != 3'd0)
                begin
                    staged[n] = make_byte(acc_byte, pie_pkg::KIND_PARTIAL, 1'b0);
                    n++;
                    acc_byte = '0;
                    acc_pos = '0;
                end
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            r = staged[k];
            r.last = (k == n - 1);
            expected_stream.push_back(r);
        end
    endtask

    task automatic queue_op(input pie_pkg::pie_mode_t op, input logic [15:0] c,
                            input int gap);
        pixel_op_t item;
        item.op = op;
        item.color = c;
        item.gap = gap;
        pending.push_back(item);
    endtask

    // Sender. Inputs change on the falling edge only. A transfer seen at the
    // last rising edge is handed to the predictor here, before any of its
    // bytes could possibly show up at the output.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_took)
            begin
                predict_stream(cur_op.op, cur_op.color);
                tx_loaded = 1'b0;
                tx_wait = 0;
                if (pending.size() != 0)
                begin
                    next_op = pending[0];
                    tx_wait = next_op.gap;
                end
            end
            if (!tx_loaded)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait = tx_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    cur_op = pending.pop_front();
                    mode <= cur_op.op;
                    color <= cur_op.color;
                    in_valid <= 1'b1;
                    tx_loaded = 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Both handshakes are sampled on the rising edge, and every
    // output transfer is checked against the oldest expected byte.
    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && !in_stall;
        rx_took <= rst_n && out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            accepted_count <= accepted_count + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_stream.size() == 0)
            begin
                fail_count++;
                $display("%0t: expected no byte, got byte %h kind %0d err %0b last %0b",
                         $time, out_byte, byte_kind, error, last);
            end
            else
            begin
                want = expected_stream.pop_front();
                if (out_byte !== want.byte_val || byte_kind !== want.kind ||
                    error !== want.err || last !== want.last)
                begin
                    fail_count++;
                    $display("%0t: expected %h/%0d/%0b/%0b, got %h/%0d/%0b/%0b",
                             $time, want.byte_val, want.kind, want.err, want.last,
                             out_byte, byte_kind, error, last);
                end
            end
        end
    end

    // Receiver: after each byte it takes, it waits a freshly drawn number of
    // cycles before it is ready again.
    always @(negedge clk)
    begin
        if (rx_took)
        begin
            rx_wait = pick_wait(rx_calm);
        end
        else if (rx_wait > 0)
        begin
            rx_wait = rx_wait - 1;
        end
        rx_stall <= (rx_wait != 0);
    end

    // One long hold-off early in the encode phase, while the sender keeps
    // offering pixels, so the block fills up and stalls its input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
        end
        else if (!hold_done && accepted_count >= hold_at)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        hold_stall <= (hold_left != 0);
    end

    initial
    begin
        wait (cycle_limit != 0 && cycle_count >= cycle_limit);
        $display("palette_index_encoder test failed");
        $finish;
    end

    initial
    begin
        logic [15:0] pool[$];
        logic [15:0] c;
        int          pool_extra;
        int          pick;

        // Colors of the test image. Black and white are always in it; the
        // rest is a random number of colors, most of them low enough for the
        // build walk to reach and a few spread over the whole range. With no
        // extra colors the index is 1 bit.
        pool.push_back(16'h0000);
        pool.push_back(16'hFFFF);
        pool_extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 60);
        for (int k = 0; k < pool_extra; k++)
        begin
            case ($urandom_range(0, 3))
                0, 1: c = 16'($urandom_range(1, BUILD_SPAN - 1));
                2: c = 16'($urandom_range(0, 31));
                default: c = 16'($urandom_range(0, 65535));
            endcase
            pool.push_back(c);
        end

        // Directed opening: encodes before any palette exists are errors, a
        // flush with nothing pending is silent, and a repeated color counts
        // only once.
        queue_op(pie_pkg::MODE_ENCODE, 16'h0000, 0);
        queue_op(pie_pkg::MODE_ENCODE, 16'h5555, 1);
        queue_op(pie_pkg::MODE_ENCODE, 16'hAAAA, 0);
        queue_op(pie_pkg::MODE_FLUSH, 16'hFFFF, 0);
        queue_op(pie_pkg::MODE_SCAN, 16'h0000, 0);
        queue_op(pie_pkg::MODE_SCAN, 16'hFFFF, 0);
        queue_op(pie_pkg::MODE_SCAN, 16'h0000, 2);

        // Scan the image: every pool color once, some of them again, and a
        // little noise of encodes and flushes.
        for (int k = 2; k < pool.size(); k++)
        begin
            queue_op(pie_pkg::MODE_SCAN, pool[k], pick_wait(tx_calm));
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, pool.size() - 1);
                queue_op(pie_pkg::MODE_SCAN, pool[pick], pick_wait(tx_calm));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                queue_op(($urandom_range(0, 1) == 0) ? pie_pkg::MODE_ENCODE
                                                     : pie_pkg::MODE_FLUSH,
                         16'($urandom_range(0, 65535)), pick_wait(tx_calm));
            end
        end

        // The first build step carries the header and the entry for color 0.
        // Right after it a scan is ignored, color 0 already has its index and
        // white is not reached yet.
        queue_op(pie_pkg::MODE_BUILD, 16'h0000, 0);
        queue_op(pie_pkg::MODE_SCAN, 16'h1234, 0);
        queue_op(pie_pkg::MODE_ENCODE, 16'h0000, 0);
        queue_op(pie_pkg::MODE_ENCODE, 16'hFFFF, 0);

        // Walk the low part of the color range, mostly back to back. Pool
        // colors are encoded on the way, both behind and ahead of the build
        // cursor.
        for (int v = 1; v < BUILD_SPAN; v++)
        begin
            queue_op(pie_pkg::MODE_BUILD, 16'($urandom_range(0, 65535)),
                     ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6) : 0);
            if ($urandom_range(0, 15) == 0)
            begin
                pick = $urandom_range(0, pool.size() - 1);
                queue_op(pie_pkg::MODE_ENCODE, pool[pick], 0);
            end
            if ($urandom_range(0, 63) == 0)
            begin
                queue_op(pie_pkg::MODE_FLUSH, 16'h0000, 0);
            end
            if ($urandom_range(0, 63) == 0)
            begin
                queue_op(pie_pkg::MODE_SCAN, 16'($urandom_range(0, 65535)), 0);
            end
        end

        // The extremes of the encode phase and a double flush whose second
        // half must stay silent.
        queue_op(pie_pkg::MODE_ENCODE, 16'h0000, 0);
        queue_op(pie_pkg::MODE_ENCODE, 16'hFFFF, 0);
        queue_op(pie_pkg::MODE_ENCODE, 16'h1234, 0);
        queue_op(pie_pkg::MODE_FLUSH, 16'h0000, 0);
        queue_op(pie_pkg::MODE_FLUSH, 16'h0000, 0);

        // Encode the image in random order, with absent colors, flushes and
        // stray scan and build steps mixed in.
        hold_at = pending.size() + 15;
        while (pending.size() < ITEMS - 1)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                queue_op(pie_pkg::MODE_ENCODE, pool[$urandom_range(0, pool.size() - 1)],
                         pick_wait(tx_calm));
            end
            else if (pick < 83)
            begin
                queue_op(pie_pkg::MODE_ENCODE, 16'($urandom_range(0, 65535)),
                         pick_wait(tx_calm));
            end
            else if (pick < 90)
            begin
                queue_op(pie_pkg::MODE_FLUSH, 16'($urandom_range(0, 65535)),
                         pick_wait(tx_calm));
            end
            else if (pick < 95)
            begin
                queue_op(pie_pkg::MODE_SCAN, 16'($urandom_range(0, 65535)),
                         pick_wait(tx_calm));
            end
            else
            begin
                queue_op(pie_pkg::MODE_BUILD, 16'($urandom_range(0, 65535)),
                         pick_wait(tx_calm));
            end
        end
        queue_op(pie_pkg::MODE_FLUSH, 16'h0000, 0);

        // Worst case per transfer: the longest sender gap, the time in the block
        // and four bytes that each sit out the longest receiver wait.
        // The bitmap clearing after reset and the hold-off come on top.
        cycle_limit = 3 * (2000 + longint'(pending.size()) * (6 + 2 + 4 * 8)
                           + HOLD_CYCLES + TAIL_CYCLES);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || tx_loaded || expected_stream.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("palette_index_encoder test passed");
        end
        else
        begin
            $display("palette_index_encoder test failed");
        end
        $finish;
    end

endmodule
